// File: hw/rtl/brbf_pkg.sv
`timescale 1ns / 1ps

package brbf_pkg;

    // Ring geometry limits and field widths.
    localparam int MAX_BLOCKS      = 8;
    localparam int MAX_BLOCK_BYTES = 64;
    localparam int STORE_DEPTH     = MAX_BLOCKS * MAX_BLOCK_BYTES;

    localparam int BLK_W   = $clog2(MAX_BLOCKS);
    localparam int OFF_W   = $clog2(MAX_BLOCK_BYTES);
    localparam int FILL_W  = OFF_W + 1;
    localparam int BCNT_W  = BLK_W + 1;
    localparam int BYTES_W = $clog2(STORE_DEPTH) + 1;
    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int REQ_W   = 3;
    localparam int DATA_W  = 8;
    localparam int CFG_W   = 7;
    localparam int CIDX_W  = 1;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_WRITE = 3'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FREE  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_QUERY = 3'd4;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_BLOCK_SIZE  = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

    localparam logic [FILL_W-1:0] BLOCK_SIZE_RST  = 7'd64;
    localparam logic [BCNT_W-1:0] BLOCK_COUNT_RST = 4'd8;

    typedef struct packed {
        logic                   wr_en;
        logic                   rd_en;
        logic [ADDR_W-1:0]      addr;
        logic [DATA_W-1:0]      wr_data;
    } mem_req_t;

    typedef struct packed {
        logic                   ok;
        logic                   rd_sel;
        logic [BLK_W-1:0]       block_index;
        logic [OFF_W-1:0]       block_offset;
        logic [FILL_W-1:0]      block_fill;
        logic [BCNT_W-1:0]      used_blocks;
        logic [BCNT_W-1:0]      free_blocks;
        logic [BYTES_W-1:0]     used_bytes;
        logic [BYTES_W-1:0]     free_bytes;
        logic                   fault;
    } res_t;

endpackage

// File: hw/rtl/block_ring_byte_fifo_top.sv
`timescale 1ns / 1ps

// Channel    Handshake              Payload
// request    s_valid / s_ready      s_req_type, s_data_in
// result     m_valid / m_ready      m_ok, m_data_out, m_block_index, m_block_offset,
//                                   m_block_fill, m_used_blocks, m_free_blocks,
//                                   m_used_bytes, m_free_bytes, m_fault
// config     cfg_wr_en              cfg_index, cfg_wr_data
//
// A request is captured in an input register and executed against the ring state and
// byte store once the output register is free or being emptied. One request per cycle
// is sustained while results are taken, using the single store port at most once per
// request. Synchronous active-low reset empties the ring and restores 64-byte blocks,
// eight of them; the byte store is not cleared. A stalled result holds the output
// register, the input register then fills and s_ready drops until the result is taken.
module block_ring_byte_fifo_top (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [brbf_pkg::CIDX_W-1:0]         cfg_index,
    input  logic [brbf_pkg::CFG_W-1:0]          cfg_wr_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [brbf_pkg::REQ_W-1:0]          s_req_type,
    input  logic [brbf_pkg::DATA_W-1:0]         s_data_in,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_ok,
    output logic [brbf_pkg::DATA_W-1:0]         m_data_out,
    output logic [brbf_pkg::BLK_W-1:0]          m_block_index,
    output logic [brbf_pkg::OFF_W-1:0]          m_block_offset,
    output logic [brbf_pkg::FILL_W-1:0]         m_block_fill,
    output logic [brbf_pkg::BCNT_W-1:0]         m_used_blocks,
    output logic [brbf_pkg::BCNT_W-1:0]         m_free_blocks,
    output logic [brbf_pkg::BYTES_W-1:0]        m_used_bytes,
    output logic [brbf_pkg::BYTES_W-1:0]        m_free_bytes,
    output logic                                m_fault
);

    // Input register stage.
    logic                           in_valid_reg, in_valid_next;
    logic [brbf_pkg::REQ_W-1:0]     in_req_reg;
    logic [brbf_pkg::DATA_W-1:0]    in_data_reg;

    // Output register stage.
    logic                           out_valid_reg, out_valid_next;
    brbf_pkg::res_t                 out_res_reg;

    logic                           exec;
    logic                           s_take;
    brbf_pkg::mem_req_t             mem_req;
    brbf_pkg::res_t                 res;
    logic [brbf_pkg::DATA_W-1:0]    mem_rd_data;

    // The held request executes once the output register is free or being emptied.
    assign exec    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || exec;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (exec) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (exec) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_req_reg  <= s_req_type;
            in_data_reg <= s_data_in;
        end
        if (exec) begin
            out_res_reg <= res;
        end
    end

    brbf_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .exec        (exec),
        .req_type    (in_req_reg),
        .data_in     (in_data_reg),
        .mem_req     (mem_req),
        .res         (res)
    );

    // The read data register of the store is loaded only when a request executes,
    // so it stays aligned with the output register while a result is stalled.
    brbf_mem u_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    assign m_valid        = out_valid_reg;
    assign m_ok           = out_res_reg.ok;
    assign m_data_out     = out_res_reg.rd_sel ? mem_rd_data : '0;
    assign m_block_index  = out_res_reg.block_index;
    assign m_block_offset = out_res_reg.block_offset;
    assign m_block_fill   = out_res_reg.block_fill;
    assign m_used_blocks  = out_res_reg.used_blocks;
    assign m_free_blocks  = out_res_reg.free_blocks;
    assign m_used_bytes   = out_res_reg.used_bytes;
    assign m_free_bytes   = out_res_reg.free_bytes;
    assign m_fault        = out_res_reg.fault;

endmodule

// File: hw/rtl/brbf_mem.sv
`timescale 1ns / 1ps

// Byte store: one port, one access per cycle, registered read data.
module brbf_mem (
    input  logic                                aclk,
    input  brbf_pkg::mem_req_t                  req,
    output logic [brbf_pkg::DATA_W-1:0]         rd_data
);

    logic [brbf_pkg::DATA_W-1:0] mem_reg [brbf_pkg::STORE_DEPTH];
    logic [brbf_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem_reg[req.addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem_reg[req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/brbf_ctrl.sv
`timescale 1ns / 1ps

// Ring state, configuration registers and the single-pass request logic.
module brbf_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [brbf_pkg::CIDX_W-1:0]         cfg_index,
    input  logic [brbf_pkg::CFG_W-1:0]          cfg_wr_data,
    input  logic                                exec,
    input  logic [brbf_pkg::REQ_W-1:0]          req_type,
    input  logic [brbf_pkg::DATA_W-1:0]         data_in,
    output brbf_pkg::mem_req_t                  mem_req,
    output brbf_pkg::res_t                      res
);

    logic [brbf_pkg::FILL_W-1:0]  size_reg;
    logic [brbf_pkg::BCNT_W-1:0]  count_reg;
    logic [brbf_pkg::FILL_W-1:0]  fill_reg [brbf_pkg::MAX_BLOCKS];
    logic [brbf_pkg::BLK_W-1:0]   rb_reg, rb_next;
    logic [brbf_pkg::BLK_W-1:0]   wb_reg, wb_next;
    logic [brbf_pkg::OFF_W-1:0]   ro_reg, ro_next;
    logic [brbf_pkg::OFF_W-1:0]   wo_reg, wo_next;
    logic [brbf_pkg::BCNT_W-1:0]  bu_reg, bu_next;
    logic [brbf_pkg::BYTES_W-1:0] bytes_reg, bytes_next;
    logic                         fault_reg, fault_next;

    logic                         fill_we;
    logic [brbf_pkg::BLK_W-1:0]   fill_widx;
    logic [brbf_pkg::FILL_W-1:0]  fill_wval;

    logic [brbf_pkg::BYTES_W-1:0] total;
    logic [brbf_pkg::FILL_W-1:0]  fill_rd, fill_wr, fill_nrd;
    logic [brbf_pkg::BLK_W-1:0]   next_rb, next_wb;
    logic [brbf_pkg::BCNT_W-1:0]  rb_inc, wb_inc;
    logic [brbf_pkg::BYTES_W-1:0] cb_free0, cb_free;
    logic [brbf_pkg::BYTES_W-1:0] ro_wide;
    logic                         rw_same, wr_ok, rd_avail;
    logic [brbf_pkg::FILL_W-1:0]  wo_inc, ro_inc, unread;
    logic [brbf_pkg::BYTES_W-1:0] bytes_dec, bytes_sub;
    logic [brbf_pkg::BCNT_W-1:0]  bu_dec;
    logic [9:0]                   rd_addr_w, wr_addr_w;
    logic [brbf_pkg::FILL_W-1:0]  cfg_size_clamp;
    logic [brbf_pkg::BCNT_W-1:0]  cfg_count_clamp;

    // Shared arithmetic for every request type.
    assign total    = 10'(size_reg) * 10'(count_reg);
    assign fill_rd  = fill_reg[rb_reg];
    assign fill_wr  = fill_reg[wb_reg];
    assign rb_inc   = {1'b0, rb_reg} + 4'd1;
    assign wb_inc   = {1'b0, wb_reg} + 4'd1;
    assign next_rb  = (rb_inc >= count_reg) ? '0 : rb_inc[brbf_pkg::BLK_W-1:0];
    assign next_wb  = (wb_inc >= count_reg) ? '0 : wb_inc[brbf_pkg::BLK_W-1:0];
    assign fill_nrd = (next_rb == rb_reg) ? '0 : fill_reg[next_rb];
    assign rw_same  = (rb_reg == wb_reg);
    assign ro_wide  = 10'(ro_reg);

    assign cb_free0 = (total > bytes_reg) ? total - bytes_reg : '0;
    always_comb begin
        cb_free = cb_free0;
        if (rw_same && (wo_reg >= ro_reg) && (ro_reg != '0)) begin
            cb_free = (cb_free0 > ro_wide) ? cb_free0 - ro_wide : '0;
        end
    end

    assign wr_ok = (cb_free != '0)
                   && !(rw_same && (fill_rd != '0) && (wo_reg == '0))
                   && (fill_wr < size_reg);
    assign wo_inc    = {1'b0, wo_reg} + 7'd1;
    assign ro_inc    = {1'b0, ro_reg} + 7'd1;
    assign rd_avail  = (bu_reg != '0) && ({1'b0, ro_reg} < fill_rd);
    assign unread    = (fill_rd > {1'b0, ro_reg}) ? fill_rd - {1'b0, ro_reg} : '0;
    assign bytes_dec = (bytes_reg != '0) ? bytes_reg - 10'd1 : '0;
    assign bytes_sub = (bytes_reg > 10'(unread)) ? bytes_reg - 10'(unread) : '0;
    assign bu_dec    = bu_reg - 4'd1;
    assign rd_addr_w = 10'(rb_reg) * 10'(size_reg) + 10'(ro_reg);
    assign wr_addr_w = 10'(wb_reg) * 10'(size_reg) + 10'(wo_reg);

    always_comb begin
        rb_next    = rb_reg;
        wb_next    = wb_reg;
        ro_next    = ro_reg;
        wo_next    = wo_reg;
        bu_next    = bu_reg;
        bytes_next = bytes_reg;
        fault_next = fault_reg;
        fill_we    = 1'b0;
        fill_widx  = rb_reg;
        fill_wval  = '0;
        mem_req    = '0;
        res        = '0;

        unique case (req_type)
            brbf_pkg::REQ_WRITE: begin
                mem_req.addr    = wr_addr_w[brbf_pkg::ADDR_W-1:0];
                mem_req.wr_data = data_in;
                if (wr_ok) begin
                    res.ok        = 1'b1;
                    mem_req.wr_en = exec;
                    fill_we       = 1'b1;
                    fill_widx     = wb_reg;
                    fill_wval     = fill_wr + 7'd1;
                    bytes_next    = bytes_reg + 10'd1;
                    if (fill_wr == '0) begin
                        bu_next = bu_reg + 4'd1;
                    end
                    if (wo_inc >= size_reg) begin
                        wo_next = '0;
                        wb_next = next_wb;
                    end else begin
                        wo_next = wo_inc[brbf_pkg::OFF_W-1:0];
                    end
                end
            end
            brbf_pkg::REQ_READ, brbf_pkg::REQ_PEEK: begin
                mem_req.addr = rd_addr_w[brbf_pkg::ADDR_W-1:0];
                if (rd_avail) begin
                    res.ok        = 1'b1;
                    res.rd_sel    = 1'b1;
                    mem_req.rd_en = exec;
                    if (req_type == brbf_pkg::REQ_READ) begin
                        bytes_next = bytes_dec;
                        if (ro_inc == fill_rd) begin
                            // Oldest block drained.
                            ro_next   = '0;
                            bu_next   = bu_dec;
                            fill_we   = 1'b1;
                            fill_widx = rb_reg;
                            if (rw_same && (wo_reg != '0)) begin
                                wo_next = '0;
                                if (bytes_dec != '0) begin
                                    fault_next = 1'b1;
                                end
                            end else begin
                                rb_next = next_rb;
                            end
                        end else begin
                            ro_next = ro_inc[brbf_pkg::OFF_W-1:0];
                        end
                    end
                end
            end
            brbf_pkg::REQ_FREE: begin
                if (bu_reg != '0) begin
                    res.ok     = 1'b1;
                    bu_next    = bu_dec;
                    bytes_next = bytes_sub;
                    ro_next    = '0;
                    fill_we    = 1'b1;
                    fill_widx  = rb_reg;
                    rb_next    = next_rb;
                    if (bu_dec != '0) begin
                        res.block_index = next_rb;
                        res.block_fill  = fill_nrd;
                    end else begin
                        wo_next = '0;
                        wb_next = next_rb;
                    end
                end
            end
            brbf_pkg::REQ_QUERY: begin
                if (bu_reg != '0) begin
                    res.ok           = 1'b1;
                    res.block_index  = rb_reg;
                    res.block_offset = ro_reg;
                    res.block_fill   = unread;
                end
            end
            default: begin
            end
        endcase

        res.used_blocks = bu_next;
        res.free_blocks = (count_reg > bu_next) ? count_reg - bu_next : '0;
        res.used_bytes  = bytes_next;
        res.free_bytes  = (total > bytes_next) ? total - bytes_next : '0;
        res.fault       = fault_next;
    end

    // Register clamping on configuration writes.
    always_comb begin
        cfg_size_clamp = cfg_wr_data;
        if (cfg_wr_data == '0) begin
            cfg_size_clamp = 7'd1;
        end else if (cfg_wr_data > 7'(brbf_pkg::MAX_BLOCK_BYTES)) begin
            cfg_size_clamp = 7'(brbf_pkg::MAX_BLOCK_BYTES);
        end
        cfg_count_clamp = cfg_wr_data[brbf_pkg::BCNT_W-1:0];
        if (cfg_count_clamp == '0) begin
            cfg_count_clamp = 4'd1;
        end else if (cfg_count_clamp > 4'(brbf_pkg::MAX_BLOCKS)) begin
            cfg_count_clamp = 4'(brbf_pkg::MAX_BLOCKS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg  <= brbf_pkg::BLOCK_SIZE_RST;
            count_reg <= brbf_pkg::BLOCK_COUNT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                brbf_pkg::CFG_BLOCK_SIZE:  size_reg  <= cfg_size_clamp;
                brbf_pkg::CFG_BLOCK_COUNT: count_reg <= cfg_count_clamp;
                default: begin
                end
            endcase
        end
    end

    // Any configuration write reinitialises the ring.
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en) begin
            for (int i = 0; i < brbf_pkg::MAX_BLOCKS; i++) begin
                fill_reg[i] <= '0;
            end
            rb_reg    <= '0;
            wb_reg    <= '0;
            ro_reg    <= '0;
            wo_reg    <= '0;
            bu_reg    <= '0;
            bytes_reg <= '0;
            fault_reg <= 1'b0;
        end else if (exec) begin
            if (fill_we) begin
                fill_reg[fill_widx] <= fill_wval;
            end
            rb_reg    <= rb_next;
            wb_reg    <= wb_next;
            ro_reg    <= ro_next;
            wo_reg    <= wo_next;
            bu_reg    <= bu_next;
            bytes_reg <= bytes_next;
            fault_reg <= fault_next;
        end
    end

endmodule
